>>> rtl/rpis_pkg.sv
// ----------------------------------------------------------------------------
// rpis_pkg
// Shared widths, codes and the queue word type of the plane inlier scorer.
// ----------------------------------------------------------------------------
package rpis_pkg;

  // Field widths
  localparam int unsigned ActW      = 2;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned NormW     = 35;
  localparam int unsigned OffW      = 52;
  localparam int unsigned OutOffW   = 51;
  localparam int unsigned CountW    = 20;
  localparam int unsigned OutCountW = 20;
  localparam int unsigned SlotW     = 2;

  // Configuration port
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam int unsigned RegIdxW = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegThr = 1'b0;
  localparam logic [ThrW-1:0] ThrReset = 16'd77;

  // Sample slots: the last one completes a hypothesis
  localparam logic [SlotW-1:0] LastSlot = 2'd2;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // Action codes on the input channel
  typedef enum logic [ActW-1:0] {
    ActSample = 2'd0,
    ActTest   = 2'd1,
    ActClose  = 2'd2,
    ActClear  = 2'd3
  } action_e;

  // Classified operations for the back end
  typedef enum logic [2:0] {
    OpStore,
    OpBuild,
    OpTest,
    OpClose,
    OpClear
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } entry_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic busy;
    logic build_done;
    logic test_done;
    logic close_fire;
  } back_sts_t;

endpackage

>>> rtl/rpis_in_if.sv
// ----------------------------------------------------------------------------
// rpis_in_if
// Input channel: action code and one signed point per word.
// ----------------------------------------------------------------------------
interface rpis_in_if;
  import rpis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ActW-1:0]          action;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;

  modport source (output valid, action, point_x, point_y, point_z, input ready);
  modport sink   (input valid, action, point_x, point_y, point_z, output ready);
endinterface

>>> rtl/rpis_out_if.sv
// ----------------------------------------------------------------------------
// rpis_out_if
// Result channel: score of a closed hypothesis and the best plane so far.
// ----------------------------------------------------------------------------
interface rpis_out_if;
  import rpis_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OutCountW-1:0]      inlier_count;
  logic                      became_best;
  logic [OutCountW-1:0]      best_count;
  logic                      best_found;
  logic signed [NormW-1:0]   best_normal_a;
  logic signed [NormW-1:0]   best_normal_b;
  logic signed [NormW-1:0]   best_normal_c;
  logic signed [OutOffW-1:0] best_offset;

  modport source (output valid, inlier_count, became_best, best_count, best_found,
                  best_normal_a, best_normal_b, best_normal_c, best_offset,
                  input ready);
  modport sink   (input valid, inlier_count, became_best, best_count, best_found,
                  best_normal_a, best_normal_b, best_normal_c, best_offset,
                  output ready);
endinterface

>>> rtl/rpis_front.sv
// ----------------------------------------------------------------------------
// rpis_front
// Accepts input words, tracks the sample slot and classifies each word.
// ----------------------------------------------------------------------------
module rpis_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  rpis_in_if.sink         in_i,
  output logic            vld_o,
  output rpis_pkg::entry_t entry_o,
  input  logic            rdy_i
);
  import rpis_pkg::*;

  logic             vld_q, vld_d;
  entry_t           entry_q, entry_d;
  logic [SlotW-1:0] fill_q, fill_d;
  logic             accept;

  // Take a word whenever the stage is empty or draining
  assign in_i.ready = !vld_q || rdy_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the incoming word
  always_comb begin
    entry_d      = entry_q;
    fill_d       = fill_q;
    vld_d        = rdy_i ? 1'b0 : vld_q;
    if (accept) begin
      vld_d        = 1'b1;
      entry_d.slot = fill_q;
      entry_d.x    = in_i.point_x;
      entry_d.y    = in_i.point_y;
      entry_d.z    = in_i.point_z;
      entry_d.op   = OpTest;
      unique case (action_e'(in_i.action))
        ActSample: begin
          if (fill_q == LastSlot) begin
            entry_d.op = OpBuild;
            fill_d     = '0;
          end else begin
            entry_d.op = OpStore;
            fill_d     = fill_q + 1'b1;
          end
        end
        ActTest:  entry_d.op = OpTest;
        ActClose: entry_d.op = OpClose;
        ActClear: entry_d.op = OpClear;
        default:  entry_d.op = OpTest;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      fill_q <= '0;
    end else begin
      vld_q <= vld_d;
      fill_q <= fill_d;
    end
  end

  // Hold the classified word
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign vld_o   = vld_q;
  assign entry_o = entry_q;
endmodule

>>> rtl/rpis_queue.sv
// ----------------------------------------------------------------------------
// rpis_queue
// Short FIFO between the classifier and the arithmetic back end.
// ----------------------------------------------------------------------------
module rpis_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_vld_i,
  input  rpis_pkg::entry_t push_entry_i,
  output logic             push_rdy_o,
  output logic             pop_vld_o,
  output rpis_pkg::entry_t pop_entry_o,
  input  logic             pop_i
);
  import rpis_pkg::*;

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             push, pop;

  assign push_rdy_o  = cnt_q != (QPtrW+1)'(QueueDepth);
  assign pop_vld_o   = cnt_q != '0;
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign push        = push_vld_i && push_rdy_o;
  assign pop         = pop_i && pop_vld_o;

  // Advance pointers and the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end
endmodule

>>> rtl/rpis_back.sv
// ----------------------------------------------------------------------------
// rpis_back
// Sequenced multiply-accumulate: builds planes, tests points, scores
// hypotheses and holds the result word.
// ----------------------------------------------------------------------------
module rpis_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_vld_i,
  input  rpis_pkg::entry_t          q_entry_i,
  output logic                      q_pop_o,
  input  logic [rpis_pkg::ThrW-1:0] thr_i,
  rpis_out_if.source                out_o,
  output rpis_pkg::back_sts_t       sts_o
);
  import rpis_pkg::*;

  // Datapath widths
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned MulAW  = 35;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned AccW   = 105;
  localparam int unsigned ShW    = 3;
  localparam int unsigned T2W    = 2 * ThrW;
  localparam int unsigned N2W    = 68;
  localparam int unsigned MagW   = 51;
  localparam int unsigned StepW  = 4;
  localparam int unsigned NumSmp = 3;
  localparam logic [StepW-1:0] LastStep = StepW'(14);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    StIdle,
    StBuild,
    StTest
  } state_e;

  typedef struct packed {
    logic             clr;
    logic             ldd;
    logic             neg;
    logic [ShW-1:0]   sh;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mac_t;

  function automatic logic [DiffW-1:0] mag_diff(logic signed [DiffW-1:0] v);
    return v[DiffW-1] ? -v : v;
  endfunction

  function automatic logic [CoordW-1:0] mag_coord(logic signed [CoordW-1:0] v);
    return v[CoordW-1] ? -v : v;
  endfunction

  function automatic logic [NormW-1:0] mag_norm(logic signed [NormW-1:0] v);
    return v[NormW-1] ? -v : v;
  endfunction

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  // Plane and score state
  logic signed [CoordW-1:0] smp_x_q [NumSmp];
  logic signed [CoordW-1:0] smp_y_q [NumSmp];
  logic signed [CoordW-1:0] smp_z_q [NumSmp];
  logic signed [CoordW-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic signed [NormW-1:0]  nrm_q [3];
  logic signed [OffW-1:0]   off_q;
  logic [N2W-1:0]           n2_q;
  logic [CountW-1:0]        cnt_q;
  logic [CountW-1:0]        best_cnt_q;
  logic signed [NormW-1:0]  best_nrm_q [3];
  logic signed [OffW-1:0]   best_off_q;
  logic                     best_vld_q;

  // Arithmetic scratch
  logic [T2W-1:0]  t2_q;
  logic [MagW-1:0] m_q;
  logic [AccW-1:0] acc_q, acc_d, acc_neg, base, term;
  logic [ProdW-1:0] prod;
  mac_t            mac;

  // Result word
  logic                      out_vld_q;
  logic [OutCountW-1:0]      res_cnt_q, res_best_cnt_q;
  logic                      res_beat_q, res_found_q;
  logic signed [NormW-1:0]   res_na_q, res_nb_q, res_nc_q;
  logic signed [OutOffW-1:0] res_off_q;

  // Control
  logic start, out_free, close_fire, clear_fire, store_fire, test_start, build_start;
  logic last, build_done, test_done, inlier, beat;

  // Operand magnitudes and signs
  logic signed [DiffW-1:0] ux, uy, uz, vx, vy, vz;
  logic [DiffW-1:0]        aux, auy, auz, avx, avy, avz;
  logic [NormW-1:0]        anx, any, anz;
  logic [CoordW-1:0]       apx, apy, apz, atx, aty, atz;

  assign ux = DiffW'(smp_x_q[1]) - DiffW'(smp_x_q[0]);
  assign uy = DiffW'(smp_y_q[1]) - DiffW'(smp_y_q[0]);
  assign uz = DiffW'(smp_z_q[1]) - DiffW'(smp_z_q[0]);
  assign vx = DiffW'(smp_x_q[2]) - DiffW'(smp_x_q[0]);
  assign vy = DiffW'(smp_y_q[2]) - DiffW'(smp_y_q[0]);
  assign vz = DiffW'(smp_z_q[2]) - DiffW'(smp_z_q[0]);

  assign aux = mag_diff(ux);
  assign auy = mag_diff(uy);
  assign auz = mag_diff(uz);
  assign avx = mag_diff(vx);
  assign avy = mag_diff(vy);
  assign avz = mag_diff(vz);
  assign anx = mag_norm(nrm_q[0]);
  assign any = mag_norm(nrm_q[1]);
  assign anz = mag_norm(nrm_q[2]);
  assign apx = mag_coord(smp_x_q[0]);
  assign apy = mag_coord(smp_y_q[0]);
  assign apz = mag_coord(smp_z_q[0]);
  assign atx = mag_coord(pt_x_q);
  assign aty = mag_coord(pt_y_q);
  assign atz = mag_coord(pt_z_q);

  // Dispatch from the queue head
  assign start       = (state_q == StIdle) && q_vld_i;
  assign out_free    = !out_vld_q || out_o.ready;
  assign close_fire  = start && (q_entry_i.op == OpClose) && out_free;
  assign clear_fire  = start && (q_entry_i.op == OpClear);
  assign store_fire  = start && ((q_entry_i.op == OpStore) || (q_entry_i.op == OpBuild));
  assign build_start = start && (q_entry_i.op == OpBuild);
  assign test_start  = start && (q_entry_i.op == OpTest);
  assign q_pop_o     = start && ((q_entry_i.op != OpClose) || out_free);

  assign last       = step_q == LastStep;
  assign build_done = (state_q == StBuild) && last;
  assign test_done  = (state_q == StTest) && last;
  assign inlier     = !acc_q[AccW-1] && (acc_q != '0);
  assign beat       = cnt_q > best_cnt_q;

  // Step table of the shared multiply-accumulate
  always_comb begin
    mac = '0;
    unique case (state_q)
      StBuild: begin
        unique case (step_q)
          // normal = (q - p) x (r - p)
          4'd0:  mac = '{clr: 1'b1, ldd: 1'b0, neg: uy[DiffW-1] ^ vz[DiffW-1], sh: '0,
                        a: MulAW'(auy), b: MulBW'(avz)};
          4'd1:  mac = '{clr: 1'b0, ldd: 1'b0, neg: !(uz[DiffW-1] ^ vy[DiffW-1]), sh: '0,
                        a: MulAW'(auz), b: MulBW'(avy)};
          4'd2:  mac = '{clr: 1'b1, ldd: 1'b0, neg: uz[DiffW-1] ^ vx[DiffW-1], sh: '0,
                        a: MulAW'(auz), b: MulBW'(avx)};
          4'd3:  mac = '{clr: 1'b0, ldd: 1'b0, neg: !(ux[DiffW-1] ^ vz[DiffW-1]), sh: '0,
                        a: MulAW'(aux), b: MulBW'(avz)};
          4'd4:  mac = '{clr: 1'b1, ldd: 1'b0, neg: ux[DiffW-1] ^ vy[DiffW-1], sh: '0,
                        a: MulAW'(aux), b: MulBW'(avy)};
          4'd5:  mac = '{clr: 1'b0, ldd: 1'b0, neg: !(uy[DiffW-1] ^ vx[DiffW-1]), sh: '0,
                        a: MulAW'(auy), b: MulBW'(avx)};
          // offset = -(n . p)
          4'd6:  mac = '{clr: 1'b1, ldd: 1'b0, neg: !(nrm_q[0][NormW-1] ^ smp_x_q[0][CoordW-1]),
                        sh: '0, a: MulAW'(anx), b: MulBW'(apx)};
          4'd7:  mac = '{clr: 1'b0, ldd: 1'b0, neg: !(nrm_q[1][NormW-1] ^ smp_y_q[0][CoordW-1]),
                        sh: '0, a: MulAW'(any), b: MulBW'(apy)};
          4'd8:  mac = '{clr: 1'b0, ldd: 1'b0, neg: !(nrm_q[2][NormW-1] ^ smp_z_q[0][CoordW-1]),
                        sh: '0, a: MulAW'(anz), b: MulBW'(apz)};
          // |n|^2, two digits per component
          4'd9:  mac = '{clr: 1'b1, ldd: 1'b0, neg: 1'b0, sh: ShW'(0),
                        a: MulAW'(anx), b: anx[MulBW-1:0]};
          4'd10: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(1),
                        a: MulAW'(anx), b: anx[2*MulBW-1:MulBW]};
          4'd11: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(0),
                        a: MulAW'(any), b: any[MulBW-1:0]};
          4'd12: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(1),
                        a: MulAW'(any), b: any[2*MulBW-1:MulBW]};
          4'd13: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(0),
                        a: MulAW'(anz), b: anz[MulBW-1:0]};
          4'd14: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(1),
                        a: MulAW'(anz), b: anz[2*MulBW-1:MulBW]};
          default: mac = '0;
        endcase
      end
      StTest: begin
        unique case (step_q)
          // threshold squared
          4'd0:  mac = '{clr: 1'b1, ldd: 1'b0, neg: 1'b0, sh: '0,
                        a: MulAW'(thr_i), b: MulBW'(thr_i)};
          // signed distance s = n . t + d
          4'd1:  mac = '{clr: 1'b0, ldd: 1'b1, neg: nrm_q[0][NormW-1] ^ pt_x_q[CoordW-1], sh: '0,
                        a: MulAW'(anx), b: MulBW'(atx)};
          4'd2:  mac = '{clr: 1'b0, ldd: 1'b0, neg: nrm_q[1][NormW-1] ^ pt_y_q[CoordW-1], sh: '0,
                        a: MulAW'(any), b: MulBW'(aty)};
          4'd3:  mac = '{clr: 1'b0, ldd: 1'b0, neg: nrm_q[2][NormW-1] ^ pt_z_q[CoordW-1], sh: '0,
                        a: MulAW'(anz), b: MulBW'(atz)};
          // |n|^2 * thr^2
          4'd4:  mac = '{clr: 1'b1, ldd: 1'b0, neg: 1'b0, sh: ShW'(0),
                        a: MulAW'(n2_q[2*MulBW-1:0]), b: t2_q[MulBW-1:0]};
          4'd5:  mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(1),
                        a: MulAW'(n2_q[2*MulBW-1:0]), b: MulBW'(t2_q[T2W-1:MulBW])};
          4'd6:  mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(2),
                        a: MulAW'(n2_q[N2W-1:2*MulBW]), b: t2_q[MulBW-1:0]};
          4'd7:  mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b0, sh: ShW'(3),
                        a: MulAW'(n2_q[N2W-1:2*MulBW]), b: MulBW'(t2_q[T2W-1:MulBW])};
          // minus s^2, low part of |s| against each digit
          4'd8:  mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b1, sh: ShW'(0),
                        a: MulAW'(m_q[2*MulBW-1:0]), b: m_q[MulBW-1:0]};
          4'd9:  mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b1, sh: ShW'(1),
                        a: MulAW'(m_q[2*MulBW-1:0]), b: m_q[2*MulBW-1:MulBW]};
          4'd10: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b1, sh: ShW'(2),
                        a: MulAW'(m_q[2*MulBW-1:0]), b: m_q[MagW-1:2*MulBW]};
          // high part of |s| against each digit
          4'd11: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b1, sh: ShW'(2),
                        a: MulAW'(m_q[MagW-1:2*MulBW]), b: m_q[MulBW-1:0]};
          4'd12: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b1, sh: ShW'(3),
                        a: MulAW'(m_q[MagW-1:2*MulBW]), b: m_q[2*MulBW-1:MulBW]};
          4'd13: mac = '{clr: 1'b0, ldd: 1'b0, neg: 1'b1, sh: ShW'(4),
                        a: MulAW'(m_q[MagW-1:2*MulBW]), b: m_q[MagW-1:2*MulBW]};
          default: mac = '0;
        endcase
      end
      default: mac = '0;
    endcase
  end

  // Multiply, align and accumulate
  assign prod    = ProdW'(mac.a) * ProdW'(mac.b);
  assign term    = AccW'(prod) << (MulBW * int'(mac.sh));
  assign base    = mac.clr ? '0 :
                   mac.ldd ? {{(AccW - OffW){off_q[OffW-1]}}, off_q} : acc_q;
  assign acc_d   = mac.neg ? base - term : base + term;
  assign acc_neg = -acc_d;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        step_d = '0;
        if (build_start) begin
          state_d = StBuild;
        end else if (test_start) begin
          state_d = StTest;
        end
      end
      StBuild, StTest: begin
        if (last) begin
          state_d = StIdle;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
      out_vld_q <= 1'b0;
      res_cnt_q <= '0;
      res_beat_q <= 1'b0;
      res_best_cnt_q <= '0;
      res_found_q <= 1'b0;
      res_na_q <= '0;
      res_nb_q <= '0;
      res_nc_q <= '0;
      res_off_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      if (close_fire) begin
        out_vld_q <= 1'b1;
        res_cnt_q <= OutCountW'(cnt_q);
        res_beat_q <= beat;
        res_best_cnt_q <= OutCountW'(beat ? cnt_q : best_cnt_q);
        res_found_q <= beat || best_vld_q;
        res_na_q <= beat ? nrm_q[0] : best_nrm_q[0];
        res_nb_q <= beat ? nrm_q[1] : best_nrm_q[1];
        res_nc_q <= beat ? nrm_q[2] : best_nrm_q[2];
        res_off_q <= OutOffW'(beat ? off_q : best_off_q);
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Current plane and running count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= '0;
      off_q <= '0;
      n2_q <= '0;
      cnt_q <= '0;
    end else begin
      if (state_q == StBuild) begin
        if (step_q == 4'd1) nrm_q[0] <= acc_d[NormW-1:0];
        if (step_q == 4'd3) nrm_q[1] <= acc_d[NormW-1:0];
        if (step_q == 4'd5) nrm_q[2] <= acc_d[NormW-1:0];
        if (step_q == 4'd8) off_q <= acc_d[OffW-1:0];
      end
      if (build_done) begin
        n2_q <= acc_d[N2W-1:0];
        cnt_q <= '0;
      end else if (test_done && inlier && (cnt_q != CountMax)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Best hypothesis so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cnt_q <= '0;
      best_nrm_q[0] <= '0;
      best_nrm_q[1] <= '0;
      best_nrm_q[2] <= '0;
      best_off_q <= '0;
      best_vld_q <= 1'b0;
    end else if (clear_fire) begin
      best_cnt_q <= '0;
      best_nrm_q[0] <= '0;
      best_nrm_q[1] <= '0;
      best_nrm_q[2] <= '0;
      best_off_q <= '0;
      best_vld_q <= 1'b0;
    end else if (close_fire && beat) begin
      best_cnt_q <= cnt_q;
      best_nrm_q[0] <= nrm_q[0];
      best_nrm_q[1] <= nrm_q[1];
      best_nrm_q[2] <= nrm_q[2];
      best_off_q <= off_q;
      best_vld_q <= 1'b1;
    end
  end

  // Sample slots, tested point and scratch registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumSmp; i++) begin
      if (store_fire && (q_entry_i.slot == SlotW'(i))) begin
        smp_x_q[i] <= q_entry_i.x;
        smp_y_q[i] <= q_entry_i.y;
        smp_z_q[i] <= q_entry_i.z;
      end
    end
    if (test_start) begin
      pt_x_q <= q_entry_i.x;
      pt_y_q <= q_entry_i.y;
      pt_z_q <= q_entry_i.z;
    end
    if (state_q != StIdle) begin
      acc_q <= acc_d;
    end
    if ((state_q == StTest) && (step_q == 4'd0)) begin
      t2_q <= acc_d[T2W-1:0];
    end
    if ((state_q == StTest) && (step_q == 4'd3)) begin
      m_q <= acc_d[AccW-1] ? acc_neg[MagW-1:0] : acc_d[MagW-1:0];
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.inlier_count  = res_cnt_q;
  assign out_o.became_best   = res_beat_q;
  assign out_o.best_count    = res_best_cnt_q;
  assign out_o.best_found    = res_found_q;
  assign out_o.best_normal_a = res_na_q;
  assign out_o.best_normal_b = res_nb_q;
  assign out_o.best_normal_c = res_nc_q;
  assign out_o.best_offset   = res_off_q;

  assign sts_o = '{busy: state_q != StIdle, build_done: build_done,
                   test_done: test_done, close_fire: close_fire};
endmodule

>>> rtl/ransac_plane_inlier_scorer.sv
// ----------------------------------------------------------------------------
// ransac_plane_inlier_scorer
// Scores plane hypotheses over fixed-point points and keeps the best plane.
//
//   channel  direction  handshake          word
//   in_i     in         valid/ready        action, point_x/y/z
//   out_o    out        valid/ready        score and best plane, on close
//   apb      in/out     psel/penable       inlier_threshold at 0x0
//
// A test point and the third sample point each hold the back end for a
// dispatch (a store for a sample) and then 15 steps of the single
// 35x17 multiply-accumulate unit that every step goes through. Other words
// need only the dispatch; a close also waits until the result register is free.
// A two-entry queue and the classifier stage let the feeder run ahead, and
// the back end keeps testing points while a result waits on the output.
// Reset clears the plane, the counts and the best plane at once.
// ----------------------------------------------------------------------------
module ransac_plane_inlier_scorer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rpis_in_if.sink                     in_i,
  rpis_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpis_pkg::PaddrW-1:0] paddr,
  input  logic [rpis_pkg::PdataW-1:0] pwdata,
  output logic [rpis_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import rpis_pkg::*;

  logic [ThrW-1:0]    thr_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_wr;
  logic               fr_vld, q_rdy, q_vld, q_pop;
  entry_t             fr_entry, q_entry;
  back_sts_t          sts;

  // Configuration register
  assign reg_idx = paddr[PaddrW-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == RegThr) ? PdataW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr && (reg_idx == RegThr)) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  rpis_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .vld_o   (fr_vld),
    .entry_o (fr_entry),
    .rdy_i   (q_rdy)
  );

  rpis_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_vld_i   (fr_vld),
    .push_entry_i (fr_entry),
    .push_rdy_o   (q_rdy),
    .pop_vld_o    (q_vld),
    .pop_entry_o  (q_entry),
    .pop_i        (q_pop)
  );

  rpis_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_vld_i   (q_vld),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .thr_i     (thr_q),
    .out_o     (out_o),
    .sts_o     (sts)
  );

  // The back end only drains a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld)
    else $error("queue popped while empty");

  // A scored close shows up on the result channel
  a_close_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.close_fire |=> out_o.valid)
    else $error("close did not raise a result word");

  // No result word appears without a close
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_o.valid && !sts.close_fire) |=> !out_o.valid)
    else $error("result word without a close");

  // A classified word is held while the queue is full
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_vld && !q_rdy) |=> fr_vld)
    else $error("classified word dropped");
endmodule

>>> dv/ransac_plane_inlier_scorer_tb.sv
// ----------------------------------------------------------------------------
// ransac_plane_inlier_scorer_tb
// Self-checking bench for the plane inlier scorer. A short table of directed
// words covers reset, plane build, the strict threshold edge, repeated close,
// clear best, coordinate extremes and a degenerate plane. Random hypotheses
// follow: three sample points, test points scattered around the plane and a
// close, mixed with broken sequences, over several threshold settings. Every
// accepted word steps a local integer scorer, and each result word is checked
// field by field against the oldest predicted score.
// ----------------------------------------------------------------------------
module ransac_plane_inlier_scorer_tb;
  import rpis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          StallLimit   = 3000;
  localparam int          HoldCycles   = 400;
  localparam int          SettleCycles = 100;
  localparam int          PhaseWords   = 158;
  localparam longint      CountMax     = (longint'(1) << CountW) - 1;
  localparam logic [PaddrW-1:0] ThrAddr = {RegThr, 2'b00};

  typedef struct packed {
    logic [OutCountW-1:0]      inlier_count;
    logic                      became_best;
    logic [OutCountW-1:0]      best_count;
    logic                      best_found;
    logic signed [NormW-1:0]   normal_a;
    logic signed [NormW-1:0]   normal_b;
    logic signed [NormW-1:0]   normal_c;
    logic signed [OutOffW-1:0] offset;
  } score_t;

  typedef struct packed {
    action_e                  act;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     typed;
    score_t                   res;
  } word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  rpis_in_if  in_if ();
  rpis_out_if out_if ();

  ransac_plane_inlier_scorer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scorer state mirrored by the bench
  longint          pts [3][3];
  int              fill_idx       = 0;
  longint          hyp_n [3]      = '{0, 0, 0};
  longint          hyp_d          = 0;
  longint          hyp_hits       = 0;
  longint          champ_n [3]    = '{0, 0, 0};
  longint          champ_d        = 0;
  longint          champ_hits     = 0;
  bit              champ_ok       = 1'b0;
  logic [ThrW-1:0] thr_now        = ThrReset;

  score_t pending_scores [$];
  word_t  dir_rows [$];
  word_t  drv_word;
  int     mismatches   = 0;
  int     words_sent   = 0;
  int     gen_fill     = 0;
  int     stall_cycles = 0;
  bit     in_pace      = 1'b1;
  bit     out_pace     = 1'b1;
  bit     hold_req     = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact squared-distance test against the current hypothesis
  function automatic bit on_plane(longint x, longint y, longint z);
    longint          sd;
    longint unsigned sm;
    logic [127:0]    lhs;
    logic [127:0]    n2;
    logic [127:0]    cm;
    logic [127:0]    t2;
    sd  = hyp_n[0] * x + hyp_n[1] * y + hyp_n[2] * z + hyp_d;
    sm  = (sd < 0) ? -sd : sd;
    lhs = 128'(sm) * 128'(sm);
    n2  = '0;
    for (int i = 0; i < 3; i++) begin
      cm = 128'((hyp_n[i] < 0) ? -hyp_n[i] : hyp_n[i]);
      n2 = n2 + cm * cm;
    end
    t2 = 128'(thr_now) * 128'(thr_now);
    return (n2 != 0) && (lhs < n2 * t2);
  endfunction

  // Step the scorer by one accepted word; a close queues its score
  function automatic void advance_scorer(word_t w);
    longint ux, uy, uz, vx, vy, vz;
    score_t sc;
    bit     beat;
    case (w.act)
      ActSample: begin
        pts[fill_idx][0] = longint'($signed(w.x));
        pts[fill_idx][1] = longint'($signed(w.y));
        pts[fill_idx][2] = longint'($signed(w.z));
        if (fill_idx == 2) begin
          ux = pts[1][0] - pts[0][0];
          uy = pts[1][1] - pts[0][1];
          uz = pts[1][2] - pts[0][2];
          vx = pts[2][0] - pts[0][0];
          vy = pts[2][1] - pts[0][1];
          vz = pts[2][2] - pts[0][2];
          hyp_n[0] = uy * vz - uz * vy;
          hyp_n[1] = uz * vx - ux * vz;
          hyp_n[2] = ux * vy - uy * vx;
          hyp_d    = -(pts[0][0] * hyp_n[0] + pts[0][1] * hyp_n[1] + pts[0][2] * hyp_n[2]);
          hyp_hits = 0;
          fill_idx = 0;
        end else begin
          fill_idx++;
        end
      end
      ActTest: begin
        if (on_plane($signed(w.x), $signed(w.y), $signed(w.z)) && hyp_hits < CountMax)
          hyp_hits++;
      end
      ActClear: begin
        champ_hits = 0;
        champ_n    = '{0, 0, 0};
        champ_d    = 0;
        champ_ok   = 1'b0;
      end
      default: begin
        beat = 1'b0;
        if (hyp_hits > champ_hits) begin
          beat       = 1'b1;
          champ_hits = hyp_hits;
          champ_n    = hyp_n;
          champ_d    = hyp_d;
          champ_ok   = 1'b1;
        end
        sc.inlier_count = OutCountW'(hyp_hits);
        sc.became_best  = beat;
        sc.best_count   = OutCountW'(champ_hits);
        sc.best_found   = champ_ok;
        sc.normal_a     = NormW'(champ_n[0]);
        sc.normal_b     = NormW'(champ_n[1]);
        sc.normal_c     = NormW'(champ_n[2]);
        sc.offset       = OutOffW'(champ_d);
        if (w.typed) sc = w.res;
        pending_scores = {pending_scores, sc};
      end
    endcase
  endfunction

  function automatic score_t mk_score(int cnt, bit beat, int best, bit found,
                                      longint a, longint b, longint c, longint d);
    score_t s;
    s.inlier_count = OutCountW'(cnt);
    s.became_best  = beat;
    s.best_count   = OutCountW'(best);
    s.best_found   = found;
    s.normal_a     = NormW'(a);
    s.normal_b     = NormW'(b);
    s.normal_c     = NormW'(c);
    s.offset       = OutOffW'(d);
    return s;
  endfunction

  function automatic word_t mk_word(action_e a, int x, int y, int z);
    word_t w;
    w     = '0;
    w.act = a;
    w.x   = CoordW'(x);
    w.y   = CoordW'(y);
    w.z   = CoordW'(z);
    return w;
  endfunction

  function automatic void add_row(action_e a, int x = 0, int y = 0, int z = 0,
                                  bit typed = 1'b0, score_t res = '0);
    word_t w;
    w       = mk_word(a, x, y, z);
    w.typed = typed;
    w.res   = res;
    dir_rows = {dir_rows, w};
  endfunction

  function automatic int any_coord();
    logic signed [CoordW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = -16'sd32768;
      1:       v = 16'sd32767;
      default: v = CoordW'($urandom);
    endcase
    return int'(v);
  endfunction

  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(word_t w);
    int gap;
    gap = in_pace ? int'($urandom_range(0, 10)) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    drv_word = w;
    in_if.valid   <= 1'b1;
    in_if.action  <= w.act;
    in_if.point_x <= w.x;
    in_if.point_y <= w.y;
    in_if.point_z <= w.z;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    if (w.act == ActSample) gen_fill = (gen_fill == 2) ? 0 : gen_fill + 1;
    words_sent++;
  endtask

  // Drop valid, wait for every score, then let the back end run dry
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the threshold, then read it back
  task automatic set_threshold(logic [ThrW-1:0] value);
    logic [PdataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ThrAddr;
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    thr_now = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[ThrW-1:0] !== value) begin
      $display("%0t: mismatch on threshold read: expected %0h, actual %0h",
               $time, value, rd[ThrW-1:0]);
      mismatches++;
    end
  endtask

  // One hypothesis: three samples, test points around the plane, close
  task automatic send_hypothesis();
    int span, nt, s, t, amp, mode;
    int a [3];
    int u [3];
    int v [3];
    int p [3];
    in_pace = ($urandom_range(0, 3) != 0);
    // realign the sample slots left open by a broken sequence
    while (gen_fill != 0)
      send_word(mk_word(ActSample, any_coord(), any_coord(), any_coord()));
    mode = int'($urandom_range(0, 15));
    case ($urandom_range(0, 2))
      0:       span = 255;
      1:       span = 4000;
      default: span = 12000;
    endcase
    foreach (a[i]) begin
      a[i] = (mode == 0) ? any_coord() : near(span);
      if (mode == 0) begin
        u[i] = any_coord() - a[i];
        v[i] = any_coord() - a[i];
      end else if (mode == 1) begin
        // collinear samples: degenerate plane
        u[i] = near(span / 2);
        v[i] = 2 * u[i];
      end else begin
        u[i] = near(span);
        v[i] = near(span);
      end
    end
    send_word(mk_word(ActSample, a[0], a[1], a[2]));
    send_word(mk_word(ActSample, a[0] + u[0], a[1] + u[1], a[2] + u[2]));
    send_word(mk_word(ActSample, a[0] + v[0], a[1] + v[1], a[2] + v[2]));
    nt = int'($urandom_range(1, 14));
    repeat (nt) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(mk_word(ActTest, any_coord(), any_coord(), any_coord()));
      end else begin
        s = int'($urandom_range(0, 16));
        t = int'($urandom_range(0, 16 - s));
        case ($urandom_range(0, 3))
          0:       amp = 0;
          1:       amp = 40;
          2:       amp = 120;
          default: amp = 600;
        endcase
        foreach (p[i]) p[i] = clamp16(a[i] + (s * u[i] + t * v[i]) / 16 + near(amp));
        send_word(mk_word(ActTest, p[0], p[1], p[2]));
      end
    end
    if ($urandom_range(0, 7) == 0) send_word(mk_word(ActClear, 0, 0, 0));
    send_word(mk_word(ActClose, any_coord(), any_coord(), any_coord()));
    if ($urandom_range(0, 7) == 0) send_word(mk_word(ActClose, 0, 0, 0));
  endtask

  // Broken sequence: a few words of any kind
  task automatic send_noise();
    int n;
    n = int'($urandom_range(1, 6));
    repeat (n)
      send_word(mk_word(action_e'(ActW'($urandom_range(0, 3))),
                        any_coord(), any_coord(), any_coord()));
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 29) == 0) out_pace = !out_pace;
      gap = out_pace ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (!out_if.valid);
      @(posedge clk_i);
    end
  end

  // Sample handshakes mid-cycle: check results, step the scorer, watch progress
  always @(negedge clk_i) begin : watch_words
    score_t want;
    bit     busy_edge;
    busy_edge = 1'b0;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        busy_edge = 1'b1;
        if (pending_scores.size() == 0) begin
          $display("%0t: mismatch: result word with no score expected, actual count %0h",
                   $time, out_if.inlier_count);
          mismatches++;
        end else begin
          want = pending_scores.pop_front();
          cmp_field("inlier_count", want.inlier_count, out_if.inlier_count);
          cmp_field("became_best", want.became_best, out_if.became_best);
          cmp_field("best_count", want.best_count, out_if.best_count);
          cmp_field("best_found", want.best_found, out_if.best_found);
          cmp_field("best_normal_a", want.normal_a, out_if.best_normal_a);
          cmp_field("best_normal_b", want.normal_b, out_if.best_normal_b);
          cmp_field("best_normal_c", want.normal_c, out_if.best_normal_c);
          cmp_field("best_offset", want.offset, out_if.best_offset);
        end
      end
      if (in_if.valid && in_if.ready) begin
        busy_edge = 1'b1;
        advance_scorer(drv_word);
      end
      if (psel && penable) busy_edge = 1'b1;
      stall_cycles = busy_edge ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: watchdog: no word moved for %0d cycles", $time, StallLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned thr_plan [9];
    int          phase_end;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.action  <= ActSample;
    in_if.point_x <= '0;
    in_if.point_y <= '0;
    in_if.point_z <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // close with nothing scored, test before any plane
    add_row(ActClose, 0, 0, 0, 1'b1, mk_score(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(ActTest, 0, 0, 0);
    add_row(ActClose, 0, 0, 0, 1'b1, mk_score(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(ActClear);
    // two samples keep the old all-zero plane in force
    add_row(ActSample, 0, 0, 0);
    add_row(ActSample, 256, 0, 0);
    add_row(ActTest, 0, 0, 0);
    // plane z = 0, normal (0, 0, 65536); a point at the threshold is out
    add_row(ActSample, 0, 256, 0);
    add_row(ActTest, 0, 0, 0);
    add_row(ActTest, 100, -100, 76);
    add_row(ActTest, 0, 0, 77);
    add_row(ActClose, 0, 0, 0, 1'b1, mk_score(2, 1, 2, 1, 0, 0, 65536, 0));
    // repeated close ties, so no promotion; after a clear it wins again
    add_row(ActClose, 0, 0, 0, 1'b1, mk_score(2, 0, 2, 1, 0, 0, 65536, 0));
    add_row(ActClear);
    add_row(ActClose, 0, 0, 0, 1'b1, mk_score(2, 1, 2, 1, 0, 0, 65536, 0));
    // coordinate extremes
    add_row(ActSample, -32768, -32768, -32768);
    add_row(ActSample, 32767, 32767, -32768);
    add_row(ActSample, 32767, -32768, 32767);
    add_row(ActTest, 32767, 32767, 32767);
    add_row(ActTest, -32768, -32768, -32768);
    add_row(ActTest, 32767, -32768, -32768);
    add_row(ActClose);
    // degenerate plane scores nothing
    add_row(ActSample, 1, 1, 1);
    add_row(ActSample, 2, 2, 2);
    add_row(ActSample, 3, 3, 3);
    add_row(ActTest, 2, 2, 2);
    add_row(ActClose);
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    settle();

    thr_plan = '{0, 65535, 1, 77, 256, 0, 0, 20, 65535};
    thr_plan[5] = $urandom_range(2, 3000);
    thr_plan[6] = $urandom_range(0, 65535);
    foreach (thr_plan[ph]) begin
      set_threshold(ThrW'(thr_plan[ph]));
      // let results back up so the input stalls
      if (ph == 2) hold_req = 1'b1;
      phase_end = words_sent + PhaseWords;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_hypothesis();
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
